[sv/bas_pkg.sv]
// Shared types and constants for the bilinear ARGB sampler.
// No dependencies; used by every module of the block.
package bas_pkg;

   localparam int PixW            = 32;
   localparam int ChanW           = 8;
   localparam int NumChan         = PixW / ChanW;
   localparam int FracInW         = 8;
   localparam int FracBitsDefault = 8;
   localparam int ReqDataW        = 4 * PixW + 2 * FracInW;

   typedef logic [PixW-1:0]    pix_type;
   typedef logic [ChanW-1:0]   chan_type;
   typedef logic [FracInW-1:0] frac_in_type;

endpackage

[sv/bas_row_blend.sv]
// Horizontal blend stage: blends top and bottom rows of each channel with fx.
// Depends on bas_pkg.
module bas_row_blend
   import bas_pkg::*;
#(
   parameter int FRAC_BITS = FracBitsDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  pix_type              in_tl,
   input  pix_type              in_tr,
   input  pix_type              in_bl,
   input  pix_type              in_br,
   input  logic [FRAC_BITS-1:0] in_fx,
   input  logic [FRAC_BITS-1:0] in_fy,
   output logic                 out_valid,
   input  logic                 out_ready,
   output pix_type              out_top,
   output pix_type              out_bot,
   output logic [FRAC_BITS-1:0] out_fy
);

   localparam int WeightW = FRAC_BITS + 1;
   localparam int SumW    = ChanW + WeightW + 1;

   logic                 valid_ff;
   logic                 valid_in;
   pix_type              top_ff, top_in;
   pix_type              bot_ff, bot_in;
   logic [FRAC_BITS-1:0] fy_ff;
   logic [WeightW-1:0]   w_far;
   logic [WeightW-1:0]   w_near;

   assign w_far  = {1'b0, in_fx};
   assign w_near = {1'b1, {FRAC_BITS{1'b0}}} - w_far;

   for (genvar c = 0; c < NumChan; c++) begin : g_chan
      logic [SumW-1:0] sum_top;
      logic [SumW-1:0] sum_bot;
      assign sum_top = SumW'(in_tl[c*ChanW +: ChanW] * w_near)
                     + SumW'(in_tr[c*ChanW +: ChanW] * w_far);
      assign sum_bot = SumW'(in_bl[c*ChanW +: ChanW] * w_near)
                     + SumW'(in_br[c*ChanW +: ChanW] * w_far);
      // convex combination, never above 255 after the shift
      assign top_in[c*ChanW +: ChanW] = sum_top[FRAC_BITS +: ChanW];
      assign bot_in[c*ChanW +: ChanW] = sum_bot[FRAC_BITS +: ChanW];
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         top_ff <= top_in;
         bot_ff <= bot_in;
         fy_ff  <= in_fy;
      end
   end

   assign out_valid = valid_ff;
   assign out_top   = top_ff;
   assign out_bot   = bot_ff;
   assign out_fy    = fy_ff;

endmodule

[sv/bas_col_blend.sv]
// Vertical blend stage and output register: blends row results with fy.
// Depends on bas_pkg.
module bas_col_blend
   import bas_pkg::*;
#(
   parameter int FRAC_BITS = FracBitsDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  pix_type              in_top,
   input  pix_type              in_bot,
   input  logic [FRAC_BITS-1:0] in_fy,
   output logic                 out_valid,
   input  logic                 out_ready,
   output pix_type              out_pix
);

   localparam int WeightW = FRAC_BITS + 1;
   localparam int SumW    = ChanW + WeightW + 1;

   logic               valid_ff;
   logic               valid_in;
   pix_type            pix_ff, pix_in;
   logic [WeightW-1:0] w_far;
   logic [WeightW-1:0] w_near;

   assign w_far  = {1'b0, in_fy};
   assign w_near = {1'b1, {FRAC_BITS{1'b0}}} - w_far;

   for (genvar c = 0; c < NumChan; c++) begin : g_chan
      logic [SumW-1:0] sum;
      assign sum = SumW'(in_top[c*ChanW +: ChanW] * w_near)
                 + SumW'(in_bot[c*ChanW +: ChanW] * w_far);
      assign pix_in[c*ChanW +: ChanW] = sum[FRAC_BITS +: ChanW];
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         pix_ff <= pix_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_pix   = pix_ff;

endmodule

[sv/bilinear_argb_sampler.sv]
// Top level of the bilinear ARGB8888 sampler: input register, row and column blends.
// Depends on bas_pkg, bas_row_blend and bas_col_blend.
//
// Bilinear sampler for ARGB8888 pixels. Each req transaction carries the four
// corner pixels and the horizontal and vertical fractions; each rsp transaction
// returns one interpolated pixel, in order. Each channel is blended across the
// top and bottom rows with fx, (left*(2^F-fx) + right*fx) >> F, truncated, and the
// two rows then with fy in the same way. F is FRAC_BITS (1..16); only the low
// FRAC_BITS bits of each fraction are used. Corners outside the image must be
// supplied as zero by the caller. Throughput is one transaction per cycle while
// rsp_tready is held high; a req transaction passes three registered stages (input register,
// horizontal multiply stage, vertical multiply stage with output register) to rsp_tvalid.
// Each stage holds its data while the one after it is stalled, so rsp_tready
// back-pressure reaches req_tready only once all three stages are full.
module bilinear_argb_sampler
   import bas_pkg::*;
#(
   parameter int FRAC_BITS = FracBitsDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // tdata from bit 0: pix_top_left[31:0], pix_top_right[63:32],
   // pix_bottom_left[95:64], pix_bottom_right[127:96], frac_x[135:128],
   // frac_y[143:136]
   input  logic [ReqDataW-1:0] req_tdata,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // tdata from bit 0: pix_out[31:0]
   output pix_type             rsp_tdata
);

   // unpacked request fields
   pix_type              req_tl, req_tr, req_bl, req_br;
   frac_in_type          req_fx, req_fy;

   // input register stage
   logic                 in_valid_ff;
   logic                 in_valid_in;
   pix_type              tl_ff, tr_ff, bl_ff, br_ff;
   logic [FRAC_BITS-1:0] fx_ff, fy_ff;
   logic                 row_ready;

   // row to column stage
   logic                 row_valid;
   logic                 col_ready;
   pix_type              row_top, row_bot;
   logic [FRAC_BITS-1:0] row_fy;

   assign req_tl = req_tdata[0*PixW +: PixW];
   assign req_tr = req_tdata[1*PixW +: PixW];
   assign req_bl = req_tdata[2*PixW +: PixW];
   assign req_br = req_tdata[3*PixW +: PixW];
   assign req_fx = req_tdata[4*PixW +: FracInW];
   assign req_fy = req_tdata[4*PixW + FracInW +: FracInW];

   assign req_tready  = !in_valid_ff || row_ready;
   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // the size cast drops fraction bits above FRAC_BITS, or zero-extends
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         tl_ff <= req_tl;
         tr_ff <= req_tr;
         bl_ff <= req_bl;
         br_ff <= req_br;
         fx_ff <= FRAC_BITS'(req_fx);
         fy_ff <= FRAC_BITS'(req_fy);
      end
   end

   bas_row_blend #(
      .FRAC_BITS (FRAC_BITS)
   ) u_row (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid_ff),
      .in_ready  (row_ready),
      .in_tl     (tl_ff),
      .in_tr     (tr_ff),
      .in_bl     (bl_ff),
      .in_br     (br_ff),
      .in_fx     (fx_ff),
      .in_fy     (fy_ff),
      .out_valid (row_valid),
      .out_ready (col_ready),
      .out_top   (row_top),
      .out_bot   (row_bot),
      .out_fy    (row_fy)
   );

   bas_col_blend #(
      .FRAC_BITS (FRAC_BITS)
   ) u_col (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (row_valid),
      .in_ready  (col_ready),
      .in_top    (row_top),
      .in_bot    (row_bot),
      .in_fy     (row_fy),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_pix   (rsp_tdata)
   );

endmodule

[dv/bilinear_argb_sampler_tb.sv]
// Self-checking testbench for the bilinear ARGB8888 sampler (bilinear_argb_sampler).
// Depends on bas_pkg and the sampler RTL; a scoreboard class predicts every rsp pixel.
`timescale 1ns / 100ps

module bilinear_argb_sampler_tb;
   import bas_pkg::*;

   localparam int FracBits   = FracBitsDefault;
   localparam int PipeDepth  = 3;       // pipeline stages from req accept to rsp_tvalid, per the RTL header
   localparam int StallLimit = 5000;    // cycles with no transaction on either side
   localparam int PhaseItems = 585;     // random transactions per flow-control phase

   typedef logic [ReqDataW-1:0] req_word_type;

   // Scoreboard: predicts the interpolated pixel for each accepted req
   // transaction and checks rsp transactions against them in order.
   class pixel_scoreboard;
      pix_type     expected_q[$];
      int unsigned frac_bits;
      int unsigned items_seen;
      int unsigned results_seen;
      int unsigned mismatches;

      function new(int unsigned fb);
         frac_bits    = fb;
         items_seen   = 0;
         results_seen = 0;
         mismatches   = 0;
      endfunction

      // Convex blend of two channel values; truncation drops the F low bits.
      function chan_type blend(chan_type near_c, chan_type far_c, longint unsigned f);
         longint unsigned unit_w;
         longint unsigned acc;
         unit_w = longint'(1) << frac_bits;
         acc    = near_c * (unit_w - f) + far_c * f;
         return chan_type'(acc >> frac_bits);
      endfunction

      function pix_type interpolate(req_word_type d);
         pix_type         tl, tr, bl, br;
         longint unsigned frac_mask, fx, fy;
         chan_type        top_c, bot_c;
         pix_type         pix;
         tl        = d[0*PixW +: PixW];
         tr        = d[1*PixW +: PixW];
         bl        = d[2*PixW +: PixW];
         br        = d[3*PixW +: PixW];
         // only the low F bits of each fraction carry weight
         frac_mask = (longint'(1) << frac_bits) - 1;
         fx        = d[4*PixW +: FracInW] & frac_mask;
         fy        = d[4*PixW+FracInW +: FracInW] & frac_mask;
         pix       = '0;
         for (int ch = 0; ch < NumChan; ch++) begin
            top_c = blend(tl[ch*ChanW +: ChanW], tr[ch*ChanW +: ChanW], fx);
            bot_c = blend(bl[ch*ChanW +: ChanW], br[ch*ChanW +: ChanW], fx);
            pix[ch*ChanW +: ChanW] = blend(top_c, bot_c, fy);
         end
         return pix;
      endfunction

      function void note_input(req_word_type d);
         expected_q.push_back(interpolate(d));
         items_seen++;
      endfunction

      task report_mismatch(string what, pix_type want, pix_type got);
         $display("MISMATCH %s: pix_out expected %08h got %08h at %0t",
                  what, want, got, $time);
         mismatches++;
      endtask

      task check_result(pix_type got);
         pix_type want;
         results_seen++;
         if (expected_q.size() == 0) begin
            report_mismatch("unexpected rsp transaction", '0, got);
         end else begin
            want = expected_q.pop_front();
            if (got !== want) begin
               report_mismatch("wrong pixel", want, got);
            end
         end
      endtask

      function int unsigned pending();
         return expected_q.size();
      endfunction
   endclass

   logic         clock;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   req_word_type req_tdata  = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   pix_type      rsp_tdata;

   int unsigned req_idle_pct = 29;
   int unsigned rsp_idle_pct = 66;
   int unsigned directed_count = 0;
   int unsigned stall_cycles   = 0;

   pixel_scoreboard sb = new(FracBits);

   bilinear_argb_sampler #(
      .FRAC_BITS (FracBits)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Receiver back-pressure, redrawn every cycle.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   // Monitor: both channels are sampled at the edge on which they handshake.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            sb.note_input(req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            sb.check_result(rsp_tdata);
         end
      end
   end

   // Watchdog: a run of cycles with no transaction at all means a hang.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
         $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                  stall_cycles, sb.pending());
         $display("bilinear_argb_sampler regression: fail");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Packs one req transaction, tl in the lowest bits, fy in the highest.
   function automatic req_word_type pack_req(pix_type tl, pix_type tr, pix_type bl,
                                             pix_type br, frac_in_type fx,
                                             frac_in_type fy);
      return {fy, fx, br, bl, tr, tl};
   endfunction

   // Corner pixel: fully random, per-channel extremes, or an outside (zero) corner.
   function automatic pix_type rand_pix();
      pix_type p;
      p = $urandom();
      case ($urandom_range(7))
         0: p = '0;
         1: begin
            for (int ch = 0; ch < NumChan; ch++) begin
               case ($urandom_range(2))
                  0: p[ch*ChanW +: ChanW] = '0;
                  1: p[ch*ChanW +: ChanW] = '1;
                  default: ;
               endcase
            end
         end
         default: ;
      endcase
      return p;
   endfunction

   // Fractions lean on zero, one step and the top code now and then.
   function automatic frac_in_type rand_frac();
      frac_in_type f;
      f = frac_in_type'($urandom());
      case ($urandom_range(9))
         0: f = '0;
         1: f = '1;
         2: f = 8'd1;
         default: ;
      endcase
      return f;
   endfunction

   // Offers one req transaction, with random idle cycles ahead of it.
   task send_item(req_word_type d);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      do @(posedge clock); while (!req_tready);
   endtask

   // Sender holds off until the pipeline has returned every pixel.
   task hold_until_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   task send_random(int unsigned n);
      for (int unsigned i = 0; i < n; i++) begin
         send_item(pack_req(rand_pix(), rand_pix(), rand_pix(), rand_pix(),
                            rand_frac(), rand_frac()));
      end
   endtask

   task send_directed(pix_type tl, pix_type tr, pix_type bl, pix_type br,
                      frac_in_type fx, frac_in_type fy);
      send_item(pack_req(tl, tr, bl, br, fx, fy));
      directed_count++;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Phase 1: sender idles 29 %, receiver 66 %. Directed cases first.
      // all-zero and all-ones corners at the fraction extremes
      send_directed('0, '0, '0, '0, '0, '0);
      send_directed('1, '1, '1, '1, '1, '1);
      send_directed('1, '1, '1, '1, '0, '0);
      send_directed('0, '0, '0, '0, '1, '1);
      // zero fractions return the top-left corner unchanged
      send_directed(32'h12345678, 32'hFFFFFFFF, 32'hA5A5A5A5, 32'h5A5A5A5A, '0, '0);
      // one corner at full scale, the others zero, at each extreme weight
      send_directed(32'hFFFFFFFF, '0, '0, '0, '0, '1);
      send_directed('0, 32'hFFFFFFFF, '0, '0, '1, '0);
      send_directed('0, '0, 32'hFFFFFFFF, '0, '0, '1);
      send_directed('0, '0, '0, 32'hFFFFFFFF, '1, '1);
      send_directed('0, '0, '0, 32'hFFFFFFFF, 8'd1, 8'd1);
      // alternating bit patterns so every input bit toggles both ways
      send_directed(32'hAAAAAAAA, 32'h55555555, 32'h55555555, 32'hAAAAAAAA,
                    8'hAA, 8'h55);
      send_directed(32'h55555555, 32'hAAAAAAAA, 32'hAAAAAAAA, 32'h55555555,
                    8'h55, 8'hAA);
      // half-way blends, distinct channel values
      send_directed(32'hFF000000, 32'h00FF0000, 32'h0000FF00, 32'h000000FF,
                    8'h80, 8'h80);
      send_directed(32'h80402010, 32'h10204080, 32'hFFFFFFFF, '0, 8'h80, 8'h7F);
      // outside corners given as transparent black on the right, bottom or top
      send_directed(32'hFFC08040, '0, '0, '0, 8'hC0, 8'h40);
      send_directed(32'hFFC08040, 32'hFF102030, '0, '0, 8'h40, 8'hFF);
      send_directed('0, '0, 32'h80FF00FF, 32'h8000FF00, 8'h01, 8'hFE);
      send_directed(32'h01010101, 32'hFEFEFEFE, 32'h01010101, 32'hFEFEFEFE,
                    8'hFF, 8'h00);
      send_random(PhaseItems);
      hold_until_drained();

      // Phase 2: sender idles 66 %, receiver 29 %.
      req_idle_pct = 66;
      rsp_idle_pct = 29;
      send_random(PhaseItems);
      hold_until_drained();

      // Phase 3: full rate both ways; back-to-back transactions.
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      send_random(PhaseItems);
      hold_until_drained();

      // allow any stray rsp transaction to surface
      repeat (PipeDepth + 5) @(posedge clock);

      $display("covered %0d req transactions (%0d directed) over three flow-control phases",
               sb.items_seen, directed_count);
      $display("%0d rsp pixels checked, %0d mismatches, %0d outstanding",
               sb.results_seen, sb.mismatches, sb.pending());
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("bilinear_argb_sampler regression: pass");
      end else begin
         $display("bilinear_argb_sampler regression: fail");
      end
      $finish;
   end

endmodule
